>>> design/cfgate_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfgate_pkg
// Shared types and codes of the command frame gate: register indexes,
// message types, error and action codes, and the structs passed between
// the gate's modules.
// ----------------------------------------------------------------------------
package cfgate_pkg;

   localparam int unsigned RESET_PAYLOAD_BYTES = 4;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GATEWAY_MAC  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GATEWAY_KNOWN = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROTO_VERSION = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_PAYLOAD  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_GAP      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESET_WINDOW = 3'd5;

   localparam logic [7:0] RESET_PROTO_VERSION = 8'd1;
   localparam logic [7:0] RESET_MAX_PAYLOAD = 8'd200;
   localparam logic [15:0] RESET_MIN_GAP = 16'd200;
   localparam logic [15:0] RESET_WINDOW = 16'd8000;

   localparam logic [7:0] MSG_STATUS    = 8'd0;
   localparam logic [7:0] MSG_REBOOT    = 8'd1;
   localparam logic [7:0] MSG_RESET     = 8'd2;
   localparam logic [7:0] MSG_TARE      = 8'd3;
   localparam logic [7:0] MSG_TELEMETRY = 8'd4;
   localparam logic [7:0] MSG_WRITE     = 8'd5;
   localparam logic [7:0] MSG_OTA       = 8'd6;

   localparam logic [2:0] ERR_NONE             = 3'd0;
   localparam logic [2:0] ERR_CRC_FAIL         = 3'd1;
   localparam logic [2:0] ERR_VERSION_MISMATCH = 3'd2;
   localparam logic [2:0] ERR_BAD_LENGTH       = 3'd3;
   localparam logic [2:0] ERR_STALE_SEQ        = 3'd4;
   localparam logic [2:0] ERR_TOO_FREQUENT     = 3'd5;
   localparam logic [2:0] ERR_UNSUPPORTED      = 3'd6;

   localparam logic [2:0] ACT_NONE          = 3'd0;
   localparam logic [2:0] ACT_REBOOT        = 3'd1;
   localparam logic [2:0] ACT_FACTORY_RESET = 3'd2;
   localparam logic [2:0] ACT_TARE          = 3'd3;
   localparam logic [2:0] ACT_TELEMETRY     = 3'd4;
   localparam logic [2:0] ACT_WRITE         = 3'd5;
   localparam logic [2:0] ACT_OTA_START     = 3'd6;

   typedef struct packed {
      logic [47:0] src_mac;
      logic        header_complete;
      logic        crc_ok;
      logic [7:0]  version;
      logic [15:0] payload_len;
      logic [31:0] seq;
      logic [7:0]  msg_type;
      logic [31:0] nonce;
      logic [31:0] now_ms;
   } frame_type;

   typedef struct packed {
      logic [47:0] gateway_mac;
      logic        gateway_known;
      logic [7:0]  protocol_version;
      logic [7:0]  max_payload;
      logic [15:0] min_command_gap_ms;
      logic [15:0] reset_window_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] last_accepted_seq;
      logic [31:0] last_command_time;
      logic        reset_armed;
      logic [31:0] armed_nonce;
      logic [31:0] arm_deadline;
   } state_type;

   typedef struct packed {
      logic        commit;
      logic [31:0] seq;
      logic [31:0] cmd_time;
      logic        arm_set;
      logic        arm_clear;
      logic [31:0] nonce;
      logic [31:0] deadline;
   } update_type;

   typedef struct packed {
      logic        ack_valid;
      logic        ack_ok;
      logic [2:0]  ack_error;
      logic [31:0] ack_seq;
      logic [31:0] ack_arg;
      logic [2:0]  action;
   } result_type;

endpackage

>>> design/command_frame_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_gate
// Admission gate for received command frame headers.
// ----------------------------------------------------------------------------
// The gate takes one decoded header beat per cycle while req_stall is low
// and returns exactly one result beat for each, through the input register
// and then the result register; rsp_ack_valid low marks a dropped frame.
// Each header is checked combinationally against the configuration and the
// gate history between the input register and the result register, and the
// history (last sequence, last command time, reset arm) is updated at the
// same edge that loads the result, so the following header always sees it.
// Configuration registers are written through csr_write, csr_index and
// csr_wdata, only while no frame is in flight: a user rule, not enforced.
// ----------------------------------------------------------------------------
module command_frame_gate
   import cfgate_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [47:0]                csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [47:0]                req_src_mac,
   input  logic                       req_header_complete,
   input  logic                       req_crc_ok,
   input  logic [7:0]                 req_version,
   input  logic [15:0]                req_payload_len,
   input  logic [31:0]                req_seq,
   input  logic [7:0]                 req_msg_type,
   input  logic [31:0]                req_nonce,
   input  logic [31:0]                req_now_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_ack_valid,
   output logic                       rsp_ack_ok,
   output logic [2:0]                 rsp_ack_error,
   output logic [31:0]                rsp_ack_seq,
   output logic [31:0]                rsp_ack_arg,
   output logic [2:0]                 rsp_action
);

   cfg_type    cfg;
   state_type  state;
   frame_type  frame_ff;
   result_type result;
   result_type result_ff;
   update_type update;
   logic       hold_valid_ff;
   logic       hold_valid_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       req_accept;
   logic       hold_move;
   logic       step;

   assign hold_move = !out_valid_ff || !rsp_stall;
   assign step = hold_valid_ff && hold_move;
   assign req_stall = hold_valid_ff && !hold_move;
   assign req_accept = req_valid && !req_stall;
   assign hold_valid_in = req_accept || (hold_valid_ff && !hold_move);
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         frame_ff.src_mac <= req_src_mac;
         frame_ff.header_complete <= req_header_complete;
         frame_ff.crc_ok <= req_crc_ok;
         frame_ff.version <= req_version;
         frame_ff.payload_len <= req_payload_len;
         frame_ff.seq <= req_seq;
         frame_ff.msg_type <= req_msg_type;
         frame_ff.nonce <= req_nonce;
         frame_ff.now_ms <= req_now_ms;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   cfgate_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cfgate_eval u_eval (
      .frame  (frame_ff),
      .cfg    (cfg),
      .state  (state),
      .result (result),
      .update (update)
   );

   cfgate_state u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .update (update),
      .state  (state)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_ack_valid = result_ff.ack_valid;
   assign rsp_ack_ok = result_ff.ack_ok;
   assign rsp_ack_error = result_ff.ack_error;
   assign rsp_ack_seq = result_ff.ack_seq;
   assign rsp_ack_arg = result_ff.ack_arg;
   assign rsp_action = result_ff.action;

   a_ok_has_no_error : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_ok |-> rsp_ack_valid && (rsp_ack_error == ERR_NONE))
      else $error("accepted beat carries an error code");

   a_action_needs_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action != ACT_NONE) |-> rsp_ack_ok)
      else $error("action issued for a rejected frame");

   a_drop_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ack_valid |-> !rsp_ack_ok && (rsp_ack_error == ERR_NONE) &&
      (rsp_ack_seq == 32'd0) && (rsp_ack_arg == 32'd0) && (rsp_action == ACT_NONE))
      else $error("dropped frame beat is not all zero");

endmodule

>>> design/cfgate_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfgate_csr
// Configuration registers of the command frame gate, written by index.
// ----------------------------------------------------------------------------
module cfgate_csr
   import cfgate_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [47:0]                csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GATEWAY_MAC:   cfg_in.gateway_mac = csr_wdata;
            REG_GATEWAY_KNOWN: cfg_in.gateway_known = csr_wdata[0];
            REG_PROTO_VERSION: cfg_in.protocol_version = csr_wdata[7:0];
            REG_MAX_PAYLOAD:   cfg_in.max_payload = csr_wdata[7:0];
            REG_MIN_GAP:       cfg_in.min_command_gap_ms = csr_wdata[15:0];
            REG_RESET_WINDOW:  cfg_in.reset_window_ms = csr_wdata[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gateway_mac        <= '0;
         cfg_ff.gateway_known      <= 1'b0;
         cfg_ff.protocol_version   <= RESET_PROTO_VERSION;
         cfg_ff.max_payload        <= RESET_MAX_PAYLOAD;
         cfg_ff.min_command_gap_ms <= RESET_MIN_GAP;
         cfg_ff.reset_window_ms    <= RESET_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/cfgate_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfgate_eval
// Decision logic for one frame: drop, header checks, replay and gap checks,
// command decode and the reset arm/confirm handshake.
// ----------------------------------------------------------------------------
module cfgate_eval
   import cfgate_pkg::*;
(
   input  frame_type  frame,
   input  cfg_type    cfg,
   input  state_type  state,
   output result_type result,
   output update_type update
);

   logic        drop;
   logic [31:0] elapsed;
   logic [31:0] arm_diff;
   logic        expired;
   logic        too_soon;

   assign drop = !cfg.gateway_known || (frame.src_mac != cfg.gateway_mac) ||
                 !frame.header_complete;
   assign elapsed = frame.now_ms - state.last_command_time;
   assign too_soon = (frame.msg_type != MSG_STATUS) &&
                     (elapsed < {16'd0, cfg.min_command_gap_ms});
   assign arm_diff = frame.now_ms - state.arm_deadline;
   assign expired = (arm_diff != 32'd0) && !arm_diff[31];

   always_comb begin
      result = '0;
      update = '0;
      update.seq = frame.seq;
      update.cmd_time = frame.now_ms;
      update.nonce = frame.nonce;
      update.deadline = frame.now_ms + {16'd0, cfg.reset_window_ms};
      if (!drop) begin
         result.ack_valid = 1'b1;
         result.ack_seq = frame.seq;
         if (frame.version != cfg.protocol_version) begin
            result.ack_error = ERR_VERSION_MISMATCH;
         end else if (frame.payload_len > {8'd0, cfg.max_payload}) begin
            result.ack_error = ERR_BAD_LENGTH;
         end else if (!frame.crc_ok) begin
            result.ack_error = ERR_CRC_FAIL;
         end else if (frame.seq <= state.last_accepted_seq) begin
            result.ack_error = ERR_STALE_SEQ;
            result.ack_arg = state.last_accepted_seq;
         end else if (too_soon) begin
            result.ack_error = ERR_TOO_FREQUENT;
         end else begin
            update.commit = 1'b1;
            result.ack_ok = 1'b1;
            case (frame.msg_type)
               MSG_STATUS:    result.action = ACT_NONE;
               MSG_REBOOT:    result.action = ACT_REBOOT;
               MSG_TARE:      result.action = ACT_TARE;
               MSG_TELEMETRY: result.action = ACT_TELEMETRY;
               MSG_WRITE:     result.action = ACT_WRITE;
               MSG_OTA: begin
                  result.action = (frame.payload_len != 16'd0) ? ACT_OTA_START : ACT_NONE;
               end
               MSG_RESET: begin
                  if (frame.payload_len < 16'(RESET_PAYLOAD_BYTES)) begin
                     result.ack_ok = 1'b0;
                     result.ack_error = ERR_BAD_LENGTH;
                  end else begin
                     result.ack_arg = frame.nonce;
                     if (!state.reset_armed || expired ||
                         (state.armed_nonce != frame.nonce)) begin
                        update.arm_set = 1'b1;
                     end else begin
                        update.arm_clear = 1'b1;
                        result.action = ACT_FACTORY_RESET;
                     end
                  end
               end
               default: begin
                  result.ack_ok = 1'b0;
                  result.ack_error = ERR_UNSUPPORTED;
               end
            endcase
         end
      end
   end

endmodule

>>> design/cfgate_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfgate_state
// Gate history: last accepted sequence and command time, and the reset arm.
// ----------------------------------------------------------------------------
module cfgate_state
   import cfgate_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  update_type update,
   output state_type  state
);

   logic [31:0] last_seq_ff;
   logic [31:0] last_seq_in;
   logic [31:0] last_time_ff;
   logic [31:0] last_time_in;
   logic        armed_ff;
   logic        armed_in;
   logic [31:0] nonce_ff;
   logic [31:0] nonce_in;
   logic [31:0] deadline_ff;
   logic [31:0] deadline_in;
   logic        commit;

   assign commit = step && update.commit;

   always_comb begin
      last_seq_in = last_seq_ff;
      last_time_in = last_time_ff;
      armed_in = armed_ff;
      nonce_in = nonce_ff;
      deadline_in = deadline_ff;
      if (commit) begin
         last_seq_in = update.seq;
         last_time_in = update.cmd_time;
         if (update.arm_set) begin
            armed_in = 1'b1;
            nonce_in = update.nonce;
            deadline_in = update.deadline;
         end else if (update.arm_clear) begin
            armed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
         last_time_ff <= '0;
         armed_ff <= 1'b0;
         nonce_ff <= '0;
         deadline_ff <= '0;
      end else begin
         last_seq_ff <= last_seq_in;
         last_time_ff <= last_time_in;
         armed_ff <= armed_in;
         nonce_ff <= nonce_in;
         deadline_ff <= deadline_in;
      end
   end

   assign state.last_accepted_seq = last_seq_ff;
   assign state.last_command_time = last_time_ff;
   assign state.reset_armed = armed_ff;
   assign state.armed_nonce = nonce_ff;
   assign state.arm_deadline = deadline_ff;

   a_hold_without_commit : assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(last_seq_ff) && $stable(armed_ff))
      else $error("gate history changed without an accepted command");

   a_seq_increases : assert property (@(posedge clock) disable iff (reset)
      commit |=> last_seq_ff > $past(last_seq_ff))
      else $error("accepted sequence number did not increase");

   a_arm_sets : assert property (@(posedge clock) disable iff (reset)
      commit && update.arm_set |=> armed_ff)
      else $error("reset arm not recorded");

endmodule
